// ===== rtl/core/rtfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Receive tuning frequency calculator package
// Shared beat types, register indexes and code constants.
// ----------------------------------------------------------------------------
package rtfc_pkg;

  localparam int unsigned FreqInW  = 40;
  localparam int unsigned FreqOutW = 42;
  localparam int unsigned ShiftW   = 32;
  localparam int unsigned RateW    = 32;
  localparam int unsigned DeltaW   = 40;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 40;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DECIM_ORDER = 3'd0,
    CFG_CENTRE_POS  = 3'd1,
    CFG_SAMPLE_RATE = 3'd2,
    CFG_SHIFT_SCH   = 3'd3,
    CFG_XVTR_EN     = 3'd4,
    CFG_XVTR_DELTA  = 3'd5
  } cfg_idx_e;

  // Centre-position codes.
  localparam logic [1:0] POS_BELOW   = 2'd0;
  localparam logic [1:0] POS_ABOVE   = 2'd1;
  localparam logic [1:0] POS_CENTRED = 2'd2;

  // Shift schemes.
  localparam logic SCH_STANDARD = 1'b0;
  localparam logic SCH_SYNC     = 1'b1;

  // Conversion direction.
  localparam logic OP_TO_DEVICE  = 1'b0;
  localparam logic OP_TO_DESIRED = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [FreqInW-1:0] frequency_in;
  } rtfc_req_t;

  typedef struct packed {
    logic signed [FreqOutW-1:0] frequency_out;
    logic signed [ShiftW-1:0]   applied_shift;
  } rtfc_rsp_t;

  // Static settings handed to the shift unit.
  typedef struct packed {
    logic [2:0]       decim_order;
    logic [1:0]       centre_pos;
    logic [RateW-1:0] sample_rate;
    logic             shift_scheme;
  } rtfc_shift_cfg_t;

endpackage

// ===== rtl/core/receive_tuning_frequency_calc.sv =====
// ----------------------------------------------------------------------------
// Receive tuning frequency calculator
// Converts a desired receive frequency to the tuner frequency, or back.
// ----------------------------------------------------------------------------
// A new beat is taken on every clock at which start is high; busy is never
// raised, so the block sustains one beat per cycle. Each beat is registered on
// entry and its result is computed by one short stage of shift, constant
// scaling and 42-bit add and clamp logic. done_o rises at the clock edge after
// the one that took the beat and stays high for exactly that one cycle, with
// rsp_o valid in it. The receiver cannot stall the block and must take every
// result in the cycle it appears. Configuration registers are read by the
// result stage, so they must only be written while no beat is in flight.
module receive_tuning_frequency_calc import rtfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rtfc_req_t           req_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                done_o,
  output rtfc_rsp_t           rsp_o
);

  // Configuration registers.
  logic [2:0]               decim_order_q;
  logic [1:0]               centre_pos_q;
  logic [RateW-1:0]         sample_rate_q;
  logic                     shift_scheme_q;
  logic                     xvtr_en_q;
  logic signed [DeltaW-1:0] xvtr_delta_q;

  // Input stage.
  logic      in_vld_q;
  rtfc_req_t in_q;

  // Result stage.
  logic      out_vld_q;
  rtfc_rsp_t rsp_q;
  rtfc_rsp_t rsp_d;

  rtfc_shift_cfg_t            shift_cfg;
  logic signed [ShiftW-1:0]   shift;
  logic signed [FreqOutW-1:0] freq_ext;
  logic signed [FreqOutW-1:0] delta_ext;
  logic signed [FreqOutW-1:0] shift_ext;
  logic signed [FreqOutW-1:0] tuned;
  logic signed [FreqOutW-1:0] sum;

  // The block never holds off a beat.
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_order_q  <= '0;
      centre_pos_q   <= POS_CENTRED;
      sample_rate_q  <= '0;
      shift_scheme_q <= SCH_STANDARD;
      xvtr_en_q      <= 1'b0;
      xvtr_delta_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DECIM_ORDER: decim_order_q  <= cfg_wdata_i[2:0];
        CFG_CENTRE_POS:  centre_pos_q   <= cfg_wdata_i[1:0];
        CFG_SAMPLE_RATE: sample_rate_q  <= cfg_wdata_i[RateW-1:0];
        CFG_SHIFT_SCH:   shift_scheme_q <= cfg_wdata_i[0];
        CFG_XVTR_EN:     xvtr_en_q      <= cfg_wdata_i[0];
        CFG_XVTR_DELTA:  xvtr_delta_q   <= $signed(cfg_wdata_i[DeltaW-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= req_i;
    end
  end

  assign shift_cfg.decim_order  = decim_order_q;
  assign shift_cfg.centre_pos   = centre_pos_q;
  assign shift_cfg.sample_rate  = sample_rate_q;
  assign shift_cfg.shift_scheme = shift_scheme_q;

  rtfc_shift u_shift (
    .cfg_i   (shift_cfg),
    .shift_o (shift)
  );

  // All intermediate values stay within 42 signed bits: the largest is the
  // input plus the largest delta and shift, the smallest is minus a delta.
  assign freq_ext  = $signed({{(FreqOutW-FreqInW){1'b0}}, in_q.frequency_in});
  assign delta_ext = xvtr_en_q ? FreqOutW'(xvtr_delta_q) : '0;
  assign shift_ext = FreqOutW'(shift);

  always_comb begin
    tuned = '0;
    sum   = '0;
    if (in_q.opcode == OP_TO_DEVICE) begin
      // Remove the transverter offset first and clamp, then take the shift.
      tuned = freq_ext - delta_ext;
      if (tuned < 0) begin
        tuned = '0;
      end
      sum = tuned - shift_ext;
    end else begin
      // Add shift and offset together, clamping the final frequency.
      sum = freq_ext + shift_ext + delta_ext;
      if (sum < 0) begin
        sum = '0;
      end
    end
    rsp_d.frequency_out = sum;
    rsp_d.applied_shift = shift;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = out_vld_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== rtl/core/rtfc_shift.sv =====
// ----------------------------------------------------------------------------
// Receive tuning shift unit
// Derives the signed tuner offset from the rate, order, scheme and position.
// ----------------------------------------------------------------------------
module rtfc_shift import rtfc_pkg::*; (
  input  rtfc_shift_cfg_t          cfg_i,
  output logic signed [ShiftW-1:0] shift_o
);

  localparam int unsigned HalfW = RateW - 1;
  localparam int unsigned ProdW = HalfW + 5;

  logic [HalfW-1:0] half;
  logic [ProdW-1:0] half_ext;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] mag_wide;
  logic [HalfW-1:0] mag;

  assign half     = cfg_i.sample_rate[RateW-1:1];
  assign half_ext = {5'd0, half};

  // Standard scheme is a plain right shift of the rate; the synchronous scheme
  // scales half the rate by a small fraction built from shifts and adds.
  always_comb begin
    prod     = '0;
    mag_wide = '0;
    if (cfg_i.shift_scheme == SCH_STANDARD) begin
      case (cfg_i.decim_order)
        3'd0:    mag_wide = '0;
        3'd1:    mag_wide = ProdW'(cfg_i.sample_rate >> 2);
        3'd2:    mag_wide = ProdW'(cfg_i.sample_rate >> 3);
        default: mag_wide = ProdW'(cfg_i.sample_rate >> cfg_i.decim_order);
      endcase
    end else begin
      case (cfg_i.decim_order)
        3'd1: begin
          prod     = half_ext;
          mag_wide = prod >> 1;
        end
        3'd2: begin
          prod     = (half_ext << 1) + half_ext;
          mag_wide = prod >> 2;
        end
        3'd3: begin
          prod     = (half_ext << 2) + half_ext;
          mag_wide = prod >> 3;
        end
        3'd4: begin
          prod     = (half_ext << 3) + (half_ext << 1) + half_ext;
          mag_wide = prod >> 4;
        end
        3'd5: begin
          prod     = (half_ext << 4) + (half_ext << 2) + half_ext;
          mag_wide = prod >> 5;
        end
        3'd6: begin
          prod     = (half_ext << 4) + (half_ext << 2) + half_ext;
          mag_wide = prod >> 6;
        end
        default: begin
          prod     = '0;
          mag_wide = '0;
        end
      endcase
    end
  end

  // The magnitude never exceeds half the rate, so 31 bits hold it.
  assign mag = mag_wide[HalfW-1:0];

  always_comb begin
    case (cfg_i.centre_pos)
      POS_BELOW: shift_o = -$signed({1'b0, mag});
      POS_ABOVE: shift_o = $signed({1'b0, mag});
      default:   shift_o = '0;
    endcase
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Receive tuning frequency calculator testbench
// Sends conversion beats in random bursts, predicts each converted frequency
// and applied shift from shadow copies of the settings, and checks every
// result against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rtfc_pkg::*;

  // Centre-position code 3 has no name in the package; the block must treat
  // it as centred.
  localparam logic [1:0] PosReserved = 2'd3;
  // Generous ceiling on the whole run, far above the slowest correct run.
  localparam int CycleLimit = 200000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  rtfc_req_t           req_i;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                done_o;
  rtfc_rsp_t           rsp_o;

  // Shadow copies of the settings, at their reset values.
  logic [2:0]         cfg_decim      = 3'd0;
  logic [1:0]         cfg_pos        = POS_CENTRED;
  logic [RateW-1:0]   cfg_rate       = '0;
  logic               cfg_scheme     = SCH_STANDARD;
  logic               cfg_xvtr_en    = 1'b0;
  logic signed [39:0] cfg_xvtr_delta = '0;

  // Predicted results, oldest first.
  rtfc_rsp_t expected_tunings[$];
  rtfc_rsp_t oldest_tuning;
  int        errors      = 0;
  int        cycle_count = 0;
  int        burst_left  = 0;

  receive_tuning_frequency_calc uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung block or a lost result must not stall the run forever.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Computes the tuner shift and the converted frequency for one beat from
  // the shadow settings. All arithmetic is done at 64 bits so that neither
  // the scaled shift nor the sum with the transverter delta can overflow.
  function automatic rtfc_rsp_t calc_tuning(input rtfc_req_t req);
    logic [63:0] rate_w;
    logic [63:0] half;
    logic [63:0] mag;
    longint      shift;
    longint      delta;
    longint      freq;
    longint      sum;
    rtfc_rsp_t   rsp;
    rate_w = {32'b0, cfg_rate};
    half   = rate_w >> 1;
    mag    = '0;
    // Only the below and above positions move the tuner; centred and the
    // unused code 3 leave it on the desired frequency.
    if (cfg_pos == POS_BELOW || cfg_pos == POS_ABOVE) begin
      if (cfg_scheme == SCH_STANDARD) begin
        if (cfg_decim == 3'd0) begin
          mag = '0;
        end else if (cfg_decim < 3'd3) begin
          mag = rate_w >> (cfg_decim + 1);
        end else begin
          mag = rate_w >> cfg_decim;
        end
      end else begin
        // Fractions of half the rate; order seven has no offset at all.
        case (cfg_decim)
          3'd1: mag = half / 2;
          3'd2: mag = (half * 3) / 4;
          3'd3: mag = (half * 5) / 8;
          3'd4: mag = (half * 11) / 16;
          3'd5: mag = (half * 21) / 32;
          3'd6: mag = (half * 21) / 64;
          default: mag = '0;
        endcase
      end
    end
    shift = (cfg_pos == POS_BELOW) ? -longint'(mag) : longint'(mag);
    delta = 0;
    if (cfg_xvtr_en) begin
      delta = longint'(cfg_xvtr_delta);
    end
    freq = longint'({24'b0, req.frequency_in});
    if (req.opcode == OP_TO_DEVICE) begin
      // The clamp sits after the transverter and before the shift, so the
      // tuner frequency itself may come out negative.
      sum = freq - delta;
      if (sum < 0) begin
        sum = 0;
      end
      sum = sum - shift;
    end else begin
      sum = freq + shift + delta;
      if (sum < 0) begin
        sum = 0;
      end
    end
    rsp.frequency_out = sum[FreqOutW-1:0];
    rsp.applied_shift = shift[ShiftW-1:0];
    return rsp;
  endfunction

  function automatic rtfc_req_t make_req(input logic op, input logic [39:0] freq);
    rtfc_req_t req;
    req.opcode       = op;
    req.frequency_in = freq;
    return req;
  endfunction

  // Picks an input frequency, leaning toward the places where the clamps
  // and the shift boundaries live.
  function automatic logic [39:0] pick_frequency();
    logic [63:0] wide;
    logic [39:0] freq;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: freq = wide[39:0];
      1: freq = 40'($urandom_range(0, 4096));
      // Around plus or minus the transverter delta, where the clamp flips.
      2: freq = ($urandom_range(0, 1) ? cfg_xvtr_delta : -cfg_xvtr_delta)
                + 40'($urandom_range(0, 64)) - 40'd32;
      // Around the shift size, where a downward shift reaches zero.
      3: freq = {8'b0, cfg_rate >> $urandom_range(1, 7)}
                + 40'($urandom_range(0, 64)) - 40'd32;
      4: freq = '1;
      default: freq = wide[39:0] >> $urandom_range(0, 39);
    endcase
    return freq;
  endfunction

  // Sends one beat and records its prediction at the edge that takes it.
  // The sender runs in bursts, with start low between them.
  task automatic send_beat(input rtfc_req_t req);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                               : $urandom_range(1, 12);
    end
    start <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (busy);
    expected_tunings.push_back(calc_tuning(req));
    burst_left--;
  endtask

  // Stops sending and waits for every outstanding result, then idles so the
  // pipeline is empty before the settings change.
  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (expected_tunings.size() != 0 && waited < 64) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_tunings.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_tunings.size());
      errors += expected_tunings.size();
      expected_tunings.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Writes all six registers back to back while the block is idle. With
  // noisy set, the unused upper data bits carry junk that must be ignored.
  task automatic configure(input logic [2:0] decim, input logic [1:0] pos,
                           input logic [RateW-1:0] rate, input logic scheme,
                           input logic xen, input logic signed [39:0] delta,
                           input bit noisy);
    logic [39:0] noise;
    drain();
    noise = noisy ? 40'({$urandom, $urandom}) : '0;
    cfg_write(CFG_DECIM_ORDER, {noise[39:3], decim});
    cfg_write(CFG_CENTRE_POS, {noise[39:2], pos});
    cfg_write(CFG_SAMPLE_RATE, {noise[39:32], rate});
    cfg_write(CFG_SHIFT_SCH, {noise[39:1], scheme});
    cfg_write(CFG_XVTR_EN, {noise[39:1], xen});
    cfg_write(CFG_XVTR_DELTA, delta);
    cfg_we_i       <= 1'b0;
    cfg_decim      = decim;
    cfg_pos        = pos;
    cfg_rate       = rate;
    cfg_scheme     = scheme;
    cfg_xvtr_en    = xen;
    cfg_xvtr_delta = delta;
  endtask

  // Settings straight out of reset: centred, so no shift in either direction.
  task automatic test_reset_state();
    send_beat(make_req(OP_TO_DEVICE, '1));
    send_beat(make_req(OP_TO_DESIRED, '0));
  endtask

  // Standard scheme at full rate: the largest shift of the two-step branch
  // and the plain-shift branch, in both directions, with the clamp at zero.
  task automatic test_standard_scheme();
    configure(3'd1, POS_ABOVE, '1, SCH_STANDARD, 1'b0, '0, 1'b0);
    send_beat(make_req(OP_TO_DEVICE, '0));
    send_beat(make_req(OP_TO_DESIRED, '1));
    configure(3'd3, POS_BELOW, '1, SCH_STANDARD, 1'b0, '0, 1'b0);
    send_beat(make_req(OP_TO_DEVICE, '0));
    send_beat(make_req(OP_TO_DESIRED, '0));
  endtask

  // Synchronous scheme: the largest fraction with the largest positive delta
  // gives the top of the to-desired output range; order seven gives no shift.
  task automatic test_sync_scheme();
    configure(3'd2, POS_ABOVE, '1, SCH_SYNC, 1'b1, 40'sh7F_FFFF_FFFF, 1'b0);
    send_beat(make_req(OP_TO_DESIRED, '1));
    configure(3'd6, POS_BELOW, '1, SCH_SYNC, 1'b0, '0, 1'b0);
    send_beat(make_req(OP_TO_DEVICE, '1));
    send_beat(make_req(OP_TO_DESIRED, 40'd12345));
    configure(3'd7, POS_ABOVE, '1, SCH_SYNC, 1'b0, '0, 1'b0);
    send_beat(make_req(OP_TO_DEVICE, 40'd12345));
  endtask

  // Transverter at both extremes of the delta, and a delta that must be
  // ignored while the transverter is off.
  task automatic test_transverter();
    configure(3'd4, POS_ABOVE, 32'd48000, SCH_STANDARD, 1'b1, 40'sh80_0000_0000, 1'b0);
    send_beat(make_req(OP_TO_DEVICE, '1));
    send_beat(make_req(OP_TO_DESIRED, '0));
    configure(3'd4, POS_ABOVE, 32'd48000, SCH_STANDARD, 1'b1, 40'sh7F_FFFF_FFFF, 1'b0);
    send_beat(make_req(OP_TO_DEVICE, 40'd1000));
    configure(3'd4, POS_ABOVE, 32'd48000, SCH_STANDARD, 1'b0, 40'sh7F_FFFF_FFFF, 1'b0);
    send_beat(make_req(OP_TO_DEVICE, 40'd1000));
  endtask

  // The unused position code behaves as centred under both schemes.
  task automatic test_position_three();
    configure(3'd3, PosReserved, '1, SCH_STANDARD, 1'b0, '0, 1'b1);
    send_beat(make_req(OP_TO_DEVICE, 40'd5000));
    send_beat(make_req(OP_TO_DESIRED, 40'd5000));
    configure(3'd4, PosReserved, '1, SCH_SYNC, 1'b0, '0, 1'b1);
    send_beat(make_req(OP_TO_DESIRED, 40'd0));
  endtask

  // A zero sample rate leaves nothing to shift by.
  task automatic test_zero_rate();
    configure(3'd5, POS_BELOW, '0, SCH_STANDARD, 1'b0, '0, 1'b0);
    send_beat(make_req(OP_TO_DEVICE, 40'd77));
    send_beat(make_req(OP_TO_DESIRED, 40'd77));
  endtask

  // Random settings per phase, each followed by a run of random beats.
  task automatic test_random_traffic();
    logic [RateW-1:0]   rate;
    logic signed [39:0] delta;
    for (int phase = 0; phase < 37; phase++) begin
      case ($urandom_range(0, 5))
        0: rate = '1;
        1: rate = '0;
        2: rate = $urandom_range(1, 100000);
        default: rate = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0: delta = 40'sh7F_FFFF_FFFF;
        1: delta = 40'sh80_0000_0000;
        2: delta = 40'($signed($urandom_range(0, 2000)) - 1000);
        default: delta = 40'({$urandom, $urandom});
      endcase
      configure(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), rate,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), delta,
                1'($urandom_range(0, 1)));
      repeat (50) send_beat(make_req(1'($urandom_range(0, 1)), pick_frequency()));
    end
  endtask

  // Every result is taken in the cycle it appears; values are sampled at the
  // edge before the block updates them, so there is no race with its logic.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_tunings.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, frequency_out %0d applied_shift %0d",
                 $time, rsp_o.frequency_out, rsp_o.applied_shift);
      end else begin
        oldest_tuning = expected_tunings.pop_front();
        if (rsp_o.frequency_out !== oldest_tuning.frequency_out) begin
          errors++;
          $display("%0t: frequency_out expected %0d actual %0d",
                   $time, oldest_tuning.frequency_out, rsp_o.frequency_out);
        end
        if (rsp_o.applied_shift !== oldest_tuning.applied_shift) begin
          errors++;
          $display("%0t: applied_shift expected %0d actual %0d",
                   $time, oldest_tuning.applied_shift, rsp_o.applied_shift);
        end
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    req_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_DECIM_ORDER;
    cfg_wdata_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_standard_scheme();
    test_sync_scheme();
    test_transverter();
    test_position_three();
    test_zero_rate();
    test_random_traffic();

    // Collect the last results, then let the block idle so that any stray
    // strobe shows.
    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== receive_tuning_frequency_calc.f =====
rtl/core/rtfc_pkg.sv
rtl/core/rtfc_shift.sv
rtl/core/receive_tuning_frequency_calc.sv
sim/testbench.sv
